### src/tcp_pkg.sv
// shared types and opcodes for the table crack partition block
package tcp_pkg;

	// request opcodes
	typedef enum logic [2:0] {
		OP_WR_CELL = 3'd0,
		OP_WR_ID   = 3'd1,
		OP_CRACK   = 3'd2,
		OP_RD_CELL = 3'd3,
		OP_RD_ID   = 3'd4
	} opcode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOP,
		ST_CMP_L,
		ST_CMP_R,
		ST_SW_RA,
		ST_SW_RB,
		ST_SW_WA,
		ST_SW_WB
	} state_t;

	localparam int DATA_W  = 64;
	localparam int SPLIT_W = 11;
	localparam int CNT_W   = 5;
	localparam logic [2:0] CFG_RESET = 3'd4;

endpackage

### src/table_crack_partition.sv
// top level of the table crack partition block
// writes and error results: one request per idle cycle, result strobed on the next cycle
// reads: result on the cycle after accept, taken from the registered memory read port
// crack: a left advance runs loop and left compare, a right step the right compare, and a
//   row exchange swaps both rows column by column; busy stays high until the result strobe
// reset clears control and sets cfg_q to 4; memory contents stay undefined
// results are strobed for one cycle on done; the receiver cannot stall
module table_crack_partition #(
	parameter int ROWS    = 1024,
	parameter int COLUMNS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [9:0]         row,
	input  logic [9:0]         row_end,
	input  logic [1:0]         column,
	input  logic signed [63:0] value,
	output logic               done,
	output logic signed [63:0] read_data,
	output logic signed [10:0] split_position,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic                         cell_we, id_we;
	logic [CW+RW-1:0]             cell_waddr, cell_raddr;
	logic [RW-1:0]                id_waddr, id_raddr;
	logic [tcp_pkg::DATA_W-1:0]   cell_wdata, cell_rdata, id_wdata, id_rdata;

	// sequencer
	tcp_ctrl #(.ROWS(ROWS), .COLUMNS(COLUMNS), .RW(RW), .CW(CW)) u_ctrl (
		.clk, .arst_n, .start, .busy, .opcode, .row, .row_end, .column, .value,
		.done, .read_data, .split_position, .status,
		.cfg_valid, .cfg_ready, .cfg_data,
		.cell_we, .cell_waddr, .cell_wdata, .cell_raddr, .cell_rdata,
		.id_we, .id_waddr, .id_wdata, .id_raddr, .id_rdata
	);

	// cell memory, addressed by column and row
	tcp_store #(.DEPTH(COLUMNS << RW), .ADDR_W(CW + RW)) u_cells (
		.clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.raddr(cell_raddr), .rdata(cell_rdata)
	);

	// id memory
	tcp_store #(.DEPTH(ROWS), .ADDR_W(RW)) u_ids (
		.clk, .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
		.raddr(id_raddr), .rdata(id_rdata)
	);

endmodule

### src/tcp_store.sv
// single-port-write, single-port-read memory with registered read data
module tcp_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [tcp_pkg::DATA_W-1:0]  wdata,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [tcp_pkg::DATA_W-1:0]  rdata
);

	logic [tcp_pkg::DATA_W-1:0] mem [0:DEPTH-1];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/tcp_ctrl.sv
// request decode and crack sequencer driving the cell and id memories
module tcp_ctrl #(
	parameter int ROWS    = 1024,
	parameter int COLUMNS = 4,
	parameter int RW      = 10,
	parameter int CW      = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     opcode,
	input  logic [9:0]                     row,
	input  logic [9:0]                     row_end,
	input  logic [1:0]                     column,
	input  logic signed [63:0]             value,
	output logic                           done,
	output logic signed [63:0]             read_data,
	output logic signed [10:0]             split_position,
	output logic                           status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_data,
	output logic                           cell_we,
	output logic [CW+RW-1:0]               cell_waddr,
	output logic [tcp_pkg::DATA_W-1:0]     cell_wdata,
	output logic [CW+RW-1:0]               cell_raddr,
	input  logic [tcp_pkg::DATA_W-1:0]     cell_rdata,
	output logic                           id_we,
	output logic [RW-1:0]                  id_waddr,
	output logic [tcp_pkg::DATA_W-1:0]     id_wdata,
	output logic [RW-1:0]                  id_raddr,
	input  logic [tcp_pkg::DATA_W-1:0]     id_rdata
);

	localparam int PW = RW + 2;
	localparam int EW = (PW > tcp_pkg::SPLIT_W) ? PW : tcp_pkg::SPLIT_W;
	localparam int NW = tcp_pkg::CNT_W;

	tcp_pkg::state_t state_q, state_d;

	logic [2:0]              cfg_q;
	logic signed [PW-1:0]    left_q, right_q;
	logic [63:0]             pivot_q;
	logic [CW-1:0]           col_q;
	logic [NW-1:0]           k_q;
	logic [63:0]             tmp_cell_q, tmp_id_q;
	logic                    done_q, status_q, rd_pend_q, rd_id_q;
	logic [10:0]             split_q;

	logic [NW-1:0]           ncols;
	logic                    accept, row_ok, end_ok, col_ok;
	logic                    l_le_r, l_lt_r, rm1_ge_l, less, last_col;
	logic signed [PW-1:0]    right_m1;
	logic signed [EW-1:0]    lm1;

	// effective column count
	always_comb begin
		if (cfg_q == 3'd0) begin
			ncols = NW'(1);
		end else if (NW'(cfg_q) > NW'(COLUMNS)) begin
			ncols = NW'(COLUMNS);
		end else begin
			ncols = NW'(cfg_q);
		end
	end

	// request checks and pointer compares
	assign accept   = start & ~busy;
	assign row_ok   = {11'd0, row} < 21'(ROWS);
	assign end_ok   = {11'd0, row_end} < 21'(ROWS);
	assign col_ok   = NW'(column) < ncols;
	assign l_le_r   = left_q <= right_q;
	assign l_lt_r   = left_q < right_q;
	assign right_m1 = right_q - PW'(1);
	assign rm1_ge_l = right_m1 >= left_q;
	assign less     = $signed(cell_rdata) < $signed(pivot_q);
	assign last_col = (k_q + NW'(1)) >= ncols;
	assign lm1      = EW'(left_q) - EW'(1);
	assign busy     = state_q != tcp_pkg::ST_IDLE;
	assign cfg_ready = ~busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcp_pkg::ST_IDLE: begin
				if (accept && opcode == tcp_pkg::OP_CRACK && row_ok && end_ok && col_ok) begin
					state_d = tcp_pkg::ST_LOOP;
				end
			end
			tcp_pkg::ST_LOOP: begin
				state_d = l_le_r ? tcp_pkg::ST_CMP_L : tcp_pkg::ST_IDLE;
			end
			tcp_pkg::ST_CMP_L: begin
				state_d = less ? tcp_pkg::ST_LOOP : tcp_pkg::ST_CMP_R;
			end
			tcp_pkg::ST_CMP_R: begin
				if (less) begin
					state_d = l_lt_r ? tcp_pkg::ST_SW_RA : tcp_pkg::ST_LOOP;
				end else if (!rm1_ge_l) begin
					state_d = tcp_pkg::ST_LOOP;
				end
			end
			tcp_pkg::ST_SW_RA: state_d = tcp_pkg::ST_SW_RB;
			tcp_pkg::ST_SW_RB: state_d = tcp_pkg::ST_SW_WA;
			tcp_pkg::ST_SW_WA: state_d = tcp_pkg::ST_SW_WB;
			tcp_pkg::ST_SW_WB: begin
				state_d = last_col ? tcp_pkg::ST_LOOP : tcp_pkg::ST_SW_RA;
			end
			default: state_d = tcp_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = {CW'(column), RW'(row)};
		cell_wdata = value;
		cell_raddr = {CW'(column), RW'(row)};
		id_we      = 1'b0;
		id_waddr   = RW'(row);
		id_wdata   = value;
		id_raddr   = RW'(row);
		case (state_q)
			tcp_pkg::ST_IDLE: begin
				cell_we = accept && opcode == tcp_pkg::OP_WR_CELL && row_ok && col_ok;
				id_we   = accept && opcode == tcp_pkg::OP_WR_ID && row_ok;
			end
			tcp_pkg::ST_LOOP: begin
				cell_raddr = {col_q, left_q[RW-1:0]};
			end
			tcp_pkg::ST_CMP_L: begin
				cell_raddr = {col_q, right_q[RW-1:0]};
			end
			tcp_pkg::ST_CMP_R: begin
				cell_raddr = {col_q, right_m1[RW-1:0]};
			end
			tcp_pkg::ST_SW_RA: begin
				cell_raddr = {k_q[CW-1:0], left_q[RW-1:0]};
				id_raddr   = left_q[RW-1:0];
			end
			tcp_pkg::ST_SW_RB: begin
				cell_raddr = {k_q[CW-1:0], right_q[RW-1:0]};
				id_raddr   = right_q[RW-1:0];
			end
			tcp_pkg::ST_SW_WA: begin
				cell_we    = 1'b1;
				cell_waddr = {k_q[CW-1:0], left_q[RW-1:0]};
				cell_wdata = cell_rdata;
				id_we      = k_q == NW'(0);
				id_waddr   = left_q[RW-1:0];
				id_wdata   = id_rdata;
			end
			tcp_pkg::ST_SW_WB: begin
				cell_we    = 1'b1;
				cell_waddr = {k_q[CW-1:0], right_q[RW-1:0]};
				cell_wdata = tmp_cell_q;
				id_we      = k_q == NW'(0);
				id_waddr   = right_q[RW-1:0];
				id_wdata   = tmp_id_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcp_pkg::ST_IDLE;
			cfg_q     <= tcp_pkg::CFG_RESET;
			done_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_id_q   <= 1'b0;
			status_q  <= 1'b0;
			split_q   <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			// results of single-cycle requests
			if (accept) begin
				split_q  <= '0;
				status_q <= 1'b0;
				case (opcode)
					tcp_pkg::OP_WR_CELL: begin
						done_q   <= 1'b1;
						status_q <= ~(row_ok & col_ok);
					end
					tcp_pkg::OP_WR_ID: begin
						done_q   <= 1'b1;
						status_q <= ~row_ok;
					end
					tcp_pkg::OP_CRACK: begin
						if (!(row_ok && end_ok && col_ok)) begin
							done_q   <= 1'b1;
							status_q <= 1'b1;
						end
					end
					tcp_pkg::OP_RD_CELL: begin
						done_q    <= 1'b1;
						status_q  <= ~(row_ok & col_ok);
						rd_pend_q <= row_ok & col_ok;
						rd_id_q   <= 1'b0;
					end
					tcp_pkg::OP_RD_ID: begin
						done_q    <= 1'b1;
						status_q  <= ~row_ok;
						rd_pend_q <= row_ok;
						rd_id_q   <= 1'b1;
					end
					default: begin
						done_q   <= 1'b1;
						status_q <= 1'b1;
					end
				endcase
			end
			// crack finish
			if (state_q == tcp_pkg::ST_LOOP && !l_le_r) begin
				done_q  <= 1'b1;
				split_q <= lm1[10:0];
			end
		end
	end

	// crack datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tcp_pkg::ST_IDLE: begin
				left_q  <= PW'(row);
				right_q <= PW'(row_end);
				pivot_q <= value;
				col_q   <= CW'(column);
			end
			tcp_pkg::ST_CMP_L: begin
				if (less) begin
					left_q <= left_q + PW'(1);
				end
			end
			tcp_pkg::ST_CMP_R: begin
				k_q <= '0;
				if (!less) begin
					right_q <= right_m1;
				end
			end
			tcp_pkg::ST_SW_RB: begin
				tmp_cell_q <= cell_rdata;
				tmp_id_q   <= id_rdata;
			end
			tcp_pkg::ST_SW_WB: begin
				k_q <= k_q + NW'(1);
				if (last_col) begin
					left_q  <= left_q + PW'(1);
					right_q <= right_m1;
				end
			end
			default: ;
		endcase
	end

	// result ports
	assign done           = done_q;
	assign status         = status_q;
	assign split_position = split_q;
	assign read_data      = !rd_pend_q ? 64'sd0 :
	                        rd_id_q ? $signed(id_rdata) : $signed(cell_rdata);

endmodule

### src/tcp_checker.sv
// port-level checker for the table crack partition block, bound to the top level
module tcp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         opcode,
	input logic               done,
	input logic signed [63:0] read_data,
	input logic signed [10:0] split_position,
	input logic               status,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// unknown opcodes report an error on the next cycle
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode != tcp_pkg::OP_WR_CELL && opcode != tcp_pkg::OP_WR_ID &&
		opcode != tcp_pkg::OP_CRACK && opcode != tcp_pkg::OP_RD_CELL &&
		opcode != tcp_pkg::OP_RD_ID |=> done && status && read_data == 0)
		else $error("unknown opcode not flagged");

	// id writes complete on the next cycle with no data
	a_wr_id: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == tcp_pkg::OP_WR_ID |=>
		done && read_data == 0 && split_position == 0)
		else $error("id write result wrong");

	// a result carries either read data or a split, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && split_position != 0 |-> read_data == 0)
		else $error("read data and split both set");

	// configuration only lands while idle
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy)
		else $error("configuration taken while busy");

endmodule

bind table_crack_partition tcp_checker u_tcp_checker (
	.clk, .arst_n, .start, .busy, .opcode, .done, .read_data, .split_position,
	.status, .cfg_valid, .cfg_ready
);

### verif/table_crack_partition_tb.sv
// testbench for the table crack partition block: directed and random requests vs a predictor
`timescale 1ns / 1ps

module table_crack_partition_tb;

	localparam int NROWS = 1024;
	localparam int NCOLS = 4;
	localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
	localparam int IDLE_LIMIT = 20000;

	// one expected result
	typedef struct {
		logic [63:0] data;
		logic [10:0] split;
		logic        err;
	} answer_t;

	// table model plus the queue of answers still owed by the block
	class table_scoreboard;
		logic [63:0] cells [NCOLS][NROWS];
		logic [63:0] ids [NROWS];
		bit          cell_set [NCOLS][NROWS];
		bit          id_set [NROWS];
		logic [2:0]  width_reg = tcp_pkg::CFG_RESET;
		answer_t     owed [$];
		int          mismatches = 0;

		function int live_cols();
			if (width_reg == 0) return 1;
			if (width_reg > NCOLS) return NCOLS;
			return width_reg;
		endfunction

		function bit row_full(int r);
			if (!id_set[r]) return 0;
			for (int c = 0; c < NCOLS; c++)
				if (!cell_set[c][r]) return 0;
			return 1;
		endfunction

		function void exchange(int a, int b);
			logic [63:0] t;
			if (a == b) return;
			t = ids[a]; ids[a] = ids[b]; ids[b] = t;
			for (int c = 0; c < live_cols(); c++) begin
				t = cells[c][a]; cells[c][a] = cells[c][b]; cells[c][b] = t;
			end
		endfunction

		// two-pointer partition, rows below the pivot end up first
		function int crack(int lo, int hi, logic signed [63:0] pivot, int c);
			int left, right;
			left = lo;
			right = hi;
			while (left <= right) begin
				if ($signed(cells[c][left]) < pivot) begin
					left++;
				end else begin
					while (right >= left && !($signed(cells[c][right]) < pivot))
						right--;
					if (left < right) begin
						exchange(left, right);
						left++;
						right--;
					end
				end
			end
			return left - 1;
		endfunction

		function void note_request(logic [2:0] op, int r, int re, int c,
				logic [63:0] v);
			answer_t a;
			bit col_ok;
			int pos;
			a.data = '0;
			a.split = '0;
			a.err = 0;
			col_ok = c < live_cols();
			case (op)
				tcp_pkg::OP_WR_CELL: begin
					if (col_ok) begin
						cells[c][r] = v;
						cell_set[c][r] = 1;
					end else a.err = 1;
				end
				tcp_pkg::OP_WR_ID: begin
					ids[r] = v;
					id_set[r] = 1;
				end
				tcp_pkg::OP_CRACK: begin
					if (col_ok) begin
						pos = crack(r, re, v, c);
						a.split = pos[10:0];
					end else a.err = 1;
				end
				tcp_pkg::OP_RD_CELL: begin
					if (col_ok) a.data = cells[c][r];
					else a.err = 1;
				end
				tcp_pkg::OP_RD_ID: a.data = ids[r];
				default: a.err = 1;
			endcase
			owed.insert(owed.size(), a);
		endfunction

		function void check_result(logic [63:0] d, logic [10:0] s, logic e);
			answer_t a;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data=%h split=%h status=%b", d, s, e);
				return;
			end
			a = owed.pop_front();
			if (a.data !== d || a.split !== s || a.err !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp data=%h split=%h status=%b, got data=%h split=%h status=%b",
						a.data, a.split, a.err, d, s, e);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         opcode;
	logic [9:0]         row;
	logic [9:0]         row_end;
	logic [1:0]         column;
	logic signed [63:0] value;
	logic               done;
	logic signed [63:0] read_data;
	logic signed [10:0] split_position;
	logic               status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_data;

	table_scoreboard sb;
	int              idle_cycles;
	int              burst_left;

	table_crack_partition #(.ROWS(NROWS), .COLUMNS(NCOLS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .row(row), .row_end(row_end), .column(column),
		.value(value), .done(done), .read_data(read_data),
		.split_position(split_position), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done && sb != null)
			sb.check_result(read_data, split_position, status);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one request, held until accepted; bursts with random gaps
	task automatic send_request(logic [2:0] op, int r, int re, int c, logic [63:0] v);
		start <= 1'b1;
		opcode <= op;
		row <= r[9:0];
		row_end <= re[9:0];
		column <= c[1:0];
		value <= v;
		do @(posedge clk); while (busy);
		sb.note_request(op, r, re, c, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	// register write once the block has drained
	task automatic write_width(logic [2:0] w);
		start <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.width_reg = w;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// pick a row, mostly in the low window, sometimes near the top
	function automatic int pick_row(bit top);
		return top ? $urandom_range(NROWS - 8, NROWS - 1) : $urandom_range(0, 47);
	endfunction

	// one random request that never reads an unwritten entry
	task automatic random_request();
		int pick, r, re, c, miss;
		bit top;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		top = $urandom_range(0, 19) == 0;
		r = pick_row(top);
		c = $urandom_range(0, NCOLS - 1);
		if (pick < 4) begin
			op = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
			send_request(op, $urandom_range(0, NROWS - 1), $urandom_range(0, NROWS - 1),
				c, rand64());
		end else if (pick < 22) begin
			send_request(tcp_pkg::OP_WR_CELL, r, 0, c, rand64());
		end else if (pick < 30) begin
			send_request(tcp_pkg::OP_WR_ID, r, 0, 0, rand64());
		end else if (pick < 50) begin
			if (c >= sb.live_cols() || sb.cell_set[c][r])
				send_request(tcp_pkg::OP_RD_CELL, r, 0, c, 0);
			else
				send_request(tcp_pkg::OP_WR_CELL, r, 0, c, rand64());
		end else if (pick < 60) begin
			if (sb.id_set[r]) send_request(tcp_pkg::OP_RD_ID, r, 0, 0, 0);
			else send_request(tcp_pkg::OP_WR_ID, r, 0, 0, rand64());
		end else begin
			re = pick_row(top);
			if (re < r && $urandom_range(0, 3) != 0) begin
				miss = r; r = re; re = miss;
			end
			// crack needs every row of the range fully written
			miss = -1;
			if (c < sb.live_cols())
				for (int k = r; k <= re; k++)
					if (miss < 0 && !sb.row_full(k)) miss = k;
			if (miss < 0) begin
				send_request(tcp_pkg::OP_CRACK, r, re, c,
					($urandom_range(0, 3) == 0 || !sb.cell_set[c][r]) ?
					rand64() : sb.cells[c][r]);
			end else if (!sb.id_set[miss]) begin
				send_request(tcp_pkg::OP_WR_ID, miss, 0, 0, rand64());
			end else begin
				for (int k = 0; k < NCOLS; k++)
					if (!sb.cell_set[k][miss]) c = k;
				if (c < sb.live_cols())
					send_request(tcp_pkg::OP_WR_CELL, miss, 0, c,
						64'($signed($urandom_range(0, 40)) - 20));
				else
					send_request(tcp_pkg::OP_WR_CELL, miss, 0, 0, rand64());
			end
		end
	endtask

	initial begin
		logic [2:0] widths [7];
		widths = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5};
		sb = new();
		burst_left = 0;
		start = 1'b0;
		opcode = tcp_pkg::OP_WR_CELL;
		row = '0;
		row_end = '0;
		column = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = tcp_pkg::CFG_RESET;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes on the top row, single-row and empty cracks, errors
		send_request(tcp_pkg::OP_WR_ID, NROWS - 1, 0, 0, 64'h8000_0000_0000_0000);
		send_request(tcp_pkg::OP_WR_CELL, NROWS - 1, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(tcp_pkg::OP_WR_CELL, NROWS - 1, 0, 1, 64'h8000_0000_0000_0000);
		send_request(tcp_pkg::OP_WR_CELL, NROWS - 1, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(tcp_pkg::OP_WR_CELL, NROWS - 1, 0, 3, 64'h0);
		send_request(tcp_pkg::OP_RD_ID, NROWS - 1, 0, 0, 0);
		send_request(tcp_pkg::OP_RD_CELL, NROWS - 1, 0, 0, 0);
		send_request(tcp_pkg::OP_RD_CELL, NROWS - 1, 0, 1, 0);
		send_request(tcp_pkg::OP_RD_CELL, NROWS - 1, 0, 3, 0);
		send_request(tcp_pkg::OP_CRACK, NROWS - 1, NROWS - 1, 0, 64'h8000_0000_0000_0000);
		send_request(tcp_pkg::OP_CRACK, NROWS - 1, NROWS - 1, 1, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(tcp_pkg::OP_CRACK, NROWS - 1, 0, 3, 0);
		send_request(tcp_pkg::OP_CRACK, 5, 0, 2, 0);
		send_request(tcp_pkg::OP_WR_ID, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(tcp_pkg::OP_RD_ID, 0, 0, 0, 0);
		send_request(OP_UNKNOWN_LO, 0, 0, 0, 0);
		send_request(OP_UNKNOWN_HI, NROWS - 1, NROWS - 1, 3, 64'hFFFF_FFFF_FFFF_FFFF);

		// random phases over several column counts
		foreach (widths[i]) begin
			write_width(widths[i]);
			repeat (170) random_request();
		end

		start <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
